>>> hw/rtl/sha1md_pkg.sv
// sha1md_pkg: constants, command/status structs and round functions
// for the sha-1 digest engine; no dependencies
`timescale 1ns / 1ps

package sha1md_pkg;

   localparam int BLOCK_BYTES  = 64;
   localparam int CNT_W        = $clog2(BLOCK_BYTES);
   localparam int WORDS        = BLOCK_BYTES / 4;
   localparam int ROUNDS       = 80;
   localparam int ROUND_W      = $clog2(ROUNDS);
   localparam int DIGEST_WORDS = 5;
   localparam int IDX_W        = $clog2(DIGEST_WORDS);
   localparam int LEN_W        = 64;
   localparam int LEN_BYTES    = LEN_W / 8;
   localparam int LIDX_W       = $clog2(LEN_BYTES);
   localparam int LEN_POS      = BLOCK_BYTES - LEN_BYTES;

   localparam logic [7:0] PAD_MARK = 8'h80;

   // source of the byte written into the block buffer
   typedef enum logic [1:0] {
      BYTE_DATA = 2'd0,
      BYTE_MARK = 2'd1,
      BYTE_ZERO = 2'd2,
      BYTE_LEN  = 2'd3
   } byte_sel_type;

   // round group: function and constant
   typedef enum logic [1:0] {
      PH_CHOOSE = 2'd0,
      PH_PARITY = 2'd1,
      PH_MAJOR  = 2'd2,
      PH_LAST   = 2'd3
   } phase_type;

   typedef struct packed {
      logic                write_byte;
      byte_sel_type        byte_sel;
      logic                len_add8;
      logic                start_block;
      logic                round_en;
      phase_type           phase;
      logic                fold;
      logic                load_out;
      logic [IDX_W-1:0]    out_index;
      logic                restart;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [31:0] init_word(input logic [IDX_W-1:0] idx);
      logic [31:0] w;
      case (idx)
         3'd0:    w = 32'h67452301;
         3'd1:    w = 32'hEFCDAB89;
         3'd2:    w = 32'h98BADCFE;
         3'd3:    w = 32'h10325476;
         default: w = 32'hC3D2E1F0;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] round_k(input phase_type ph);
      logic [31:0] k;
      case (ph)
         PH_CHOOSE: k = 32'h5A827999;
         PH_PARITY: k = 32'h6ED9EBA1;
         PH_MAJOR:  k = 32'h8F1BBCDC;
         default:   k = 32'hCA62C1D6;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] round_f(input phase_type ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (ph)
         PH_CHOOSE: f = (b & c) | (~b & d);
         PH_MAJOR:  f = (b & c) | (b & d) | (c & d);
         default:   f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

endpackage

>>> hw/rtl/sha1md_if.sv
// sha1md_req_if / sha1md_rsp_if: valid/ready channels of the digest engine
// depends on nothing
`timescale 1ns / 1ps

interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output has_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                   output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last_word,
                   output ready);
endinterface

>>> hw/rtl/sha1md_datapath.sv
// sha1md_datapath: block buffer / schedule window, round unit, chaining words,
// bit length and output word register; uses sha1md_pkg
`timescale 1ns / 1ps

module sha1md_datapath
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [7:0]  data_byte,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic [31:0]      sched_ff [WORDS];
   logic [31:0]      sched_in [WORDS];
   logic [31:0]      work_ff  [DIGEST_WORDS];
   logic [31:0]      work_in  [DIGEST_WORDS];
   logic [31:0]      chain_ff [DIGEST_WORDS];
   logic [31:0]      chain_in [DIGEST_WORDS];
   logic [LEN_W-1:0] len_ff, len_in;
   logic             out_valid_ff, out_valid_in;
   logic [31:0]      out_word_ff, out_word_in;
   logic [IDX_W-1:0] out_index_ff, out_index_in;
   logic             out_last_ff, out_last_in;
   logic [7:0]       wr_byte;
   logic [31:0]      sched_new;
   logic [31:0]      temp;

   // byte written into the buffer
   always_comb begin
      case (cmd.byte_sel)
         BYTE_DATA: wr_byte = data_byte;
         BYTE_MARK: wr_byte = PAD_MARK;
         BYTE_LEN:  wr_byte = len_ff[LEN_W-1 -: 8];
         default:   wr_byte = 8'h00;
      endcase
   end

   // buffer shifts in bytes; during rounds it slides as the schedule window
   assign sched_new = rotl(sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0], 1);

   always_comb begin
      for (int i = 0; i < WORDS; i++) begin
         sched_in[i] = sched_ff[i];
      end
      if (cmd.write_byte) begin
         for (int i = 0; i < WORDS - 1; i++) begin
            sched_in[i] = {sched_ff[i][23:0], sched_ff[i+1][31:24]};
         end
         sched_in[WORDS-1] = {sched_ff[WORDS-1][23:0], wr_byte};
      end else if (cmd.round_en) begin
         for (int i = 0; i < WORDS - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[WORDS-1] = sched_new;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WORDS; i++) begin
         sched_ff[i] <= sched_in[i];
      end
   end

   // one compression round per cycle
   assign temp = rotl(work_ff[0], 5) + round_f(cmd.phase, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + round_k(cmd.phase) + sched_ff[0];

   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         work_in[i] = work_ff[i];
      end
      if (cmd.start_block) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            work_in[i] = chain_ff[i];
         end
      end else if (cmd.round_en) begin
         work_in[0] = temp;
         work_in[1] = work_ff[0];
         work_in[2] = rotl(work_ff[1], 30);
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         work_ff[i] <= work_in[i];
      end
   end

   // chaining words: fold after a block, back to initial values after a digest
   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         chain_in[i] = chain_ff[i];
         if (cmd.restart) begin
            chain_in[i] = init_word(IDX_W'(i));
         end else if (cmd.fold) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         if (reset) begin
            chain_ff[i] <= init_word(IDX_W'(i));
         end else begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   // message bit length, shifted out a byte at a time during padding
   always_comb begin
      len_in = len_ff;
      if (cmd.restart) begin
         len_in = '0;
      end else if (cmd.len_add8) begin
         len_in = len_ff + LEN_W'(8);
      end else if (cmd.write_byte && cmd.byte_sel == BYTE_LEN) begin
         len_in = {len_ff[LEN_W-9:0], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   // output word register
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_word_in  = out_word_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_word_in  = chain_ff[cmd.out_index];
         out_index_in = cmd.out_index;
         out_last_in  = (cmd.out_index == IDX_W'(DIGEST_WORDS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_word_ff  <= out_word_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_digest_word = out_word_ff;
   assign rsp_word_index  = out_index_ff;
   assign rsp_last_word   = out_last_ff;

endmodule

>>> hw/rtl/sha1md_ctrl.sv
// sha1md_ctrl: sequencer for byte intake, compression rounds, padding and
// digest output; uses sha1md_pkg
`timescale 1ns / 1ps

module sha1md_ctrl
   import sha1md_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_has_byte,
   input  logic       req_last_byte,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_COMPRESS = 5'b00010,
      ST_FOLD     = 5'b00100,
      ST_PAD      = 5'b01000,
      ST_EMIT     = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [IDX_W-1:0]   widx_ff, widx_in;
   logic [LIDX_W-1:0]  lidx_ff, lidx_in;
   byte_sel_type       pad_ff, pad_in;
   logic               finishing_ff, finishing_in;
   logic               len_done_ff, len_done_in;
   logic               block_full;

   assign block_full = (count_ff == CNT_W'(BLOCK_BYTES - 1));

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      round_in     = round_ff;
      widx_in      = widx_ff;
      lidx_in      = lidx_ff;
      pad_in       = pad_ff;
      finishing_in = finishing_ff;
      len_done_in  = len_done_ff;
      cmd          = '0;
      cmd.byte_sel = BYTE_DATA;
      cmd.phase    = PH_CHOOSE;
      req_ready    = 1'b0;

      if (round_ff < ROUND_W'(20)) begin
         cmd.phase = PH_CHOOSE;
      end else if (round_ff < ROUND_W'(40)) begin
         cmd.phase = PH_PARITY;
      end else if (round_ff < ROUND_W'(60)) begin
         cmd.phase = PH_MAJOR;
      end else begin
         cmd.phase = PH_LAST;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               finishing_in = req_last_byte;
               pad_in       = BYTE_MARK;
               lidx_in      = '0;
               len_done_in  = 1'b0;
               if (req_has_byte) begin
                  cmd.write_byte = 1'b1;
                  cmd.byte_sel   = BYTE_DATA;
                  cmd.len_add8   = 1'b1;
               end
               if (req_has_byte && block_full) begin
                  cmd.start_block = 1'b1;
                  round_in        = '0;
                  state_in        = ST_COMPRESS;
               end else if (req_last_byte) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMPRESS: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + ROUND_W'(1);
            if (round_ff == ROUND_W'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!finishing_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               widx_in  = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            cmd.write_byte = 1'b1;
            cmd.byte_sel   = pad_ff;
            if (pad_ff == BYTE_LEN) begin
               lidx_in = lidx_ff + LIDX_W'(1);
               if (lidx_ff == LIDX_W'(LEN_BYTES - 1)) begin
                  len_done_in = 1'b1;
               end
            end else if (count_ff == CNT_W'(LEN_POS - 1)) begin
               pad_in = BYTE_LEN;
            end else begin
               pad_in = BYTE_ZERO;
            end
            if (block_full) begin
               cmd.start_block = 1'b1;
               round_in        = '0;
               state_in        = ST_COMPRESS;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.out_index = widx_ff;
               widx_in       = widx_ff + IDX_W'(1);
               if (widx_ff == IDX_W'(DIGEST_WORDS - 1)) begin
                  cmd.restart  = 1'b1;
                  finishing_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // bytes held in the block buffer
      if (cmd.restart) begin
         count_in = '0;
      end else if (cmd.write_byte) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         round_ff     <= '0;
         widx_ff      <= '0;
         lidx_ff      <= '0;
         pad_ff       <= BYTE_MARK;
         finishing_ff <= 1'b0;
         len_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         widx_ff      <= widx_in;
         lidx_ff      <= lidx_in;
         pad_ff       <= pad_in;
         finishing_ff <= finishing_in;
         len_done_ff  <= len_done_in;
      end
   end

endmodule

>>> hw/rtl/sha1_message_digest.sv
// sha1_message_digest: streaming sha-1 engine, top level
// depends on sha1md_pkg, sha1md_if, sha1md_ctrl, sha1md_datapath
//
//   channel  dir  payload                                  word accepted when
//   req_ch   in   data_byte[7:0] has_byte last_byte        valid && ready
//   rsp_ch   out  digest_word[31:0] word_index[2:0]        valid && ready
//                 last_word
//
// a word that neither fills a 64-byte block nor is a last word is taken with req_ch
// kept ready; the word that fills a block loads it, then the single round unit runs
// all rounds and the block is folded; a last word adds its padding bytes (9 to 72,
// above 64 over two blocks) and the rounds and fold of each padded block, then five
// digest words, one a cycle while rsp_ch is ready; reset is synchronous, and req_ch
// is ready in the cycle after reset drops; a stalled rsp_ch holds the digest sequence;
// the last digest word waits in the output register while req_ch takes the next word
`timescale 1ns / 1ps

module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sha1md_req_if.sink   req_ch,
   sha1md_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   sha1md_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_has_byte  (req_ch.has_byte),
      .req_last_byte (req_ch.last_byte),
      .status        (status),
      .cmd           (cmd)
   );

   // buffer, rounds and output register
   sha1md_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .data_byte       (req_ch.data_byte),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_digest_word (rsp_ch.digest_word),
      .rsp_word_index  (rsp_ch.word_index),
      .rsp_last_word   (rsp_ch.last_word)
   );

endmodule

>>> tb/sha1_message_digest_tb.sv
// sha1_message_digest_tb: self-checking bench for the streaming sha-1 engine,
// byte words in, five digest words out, each checked against a behavioral sha-1 or a
// hand-written digest; depends on sha1md_pkg, sha1md_if and sha1_message_digest
`timescale 1ns / 1ps

module sha1_message_digest_tb
   import sha1md_pkg::*;
();

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int ITEM_TARGET   = 380;
   localparam int PAUSE_AT_MSG  = 4;
   localparam int HOLD_AFTER    = 37;
   localparam int LONG_HOLD     = 400;
   localparam int TAIL_CYCLES   = 200;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int DIRECTED_ROWS = 12;

   localparam logic [159:0] SHA1_IV =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
   localparam logic [159:0] EMPTY_DIGEST =
      160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam logic [159:0] NO_DIGEST = 160'h0;

   localparam logic [31:0] K_CHOOSE = 32'h5A827999;
   localparam logic [31:0] K_PARITY = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJOR  = 32'h8F1BBCDC;
   localparam logic [31:0] K_LAST   = 32'hCA62C1D6;

   // one input word; typed rows carry their digest written out by hand
   typedef struct packed {
      logic [7:0]   data;
      logic         has;
      logic         last;
      logic         typed;
      logic [159:0] digest;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic clock;
   logic reset;

   sha1md_req_if req_ch ();
   sha1md_rsp_if rsp_ch ();

   sha1_message_digest DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // directed words: data, has, last, typed, digest
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message right after reset
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // neither flag
      '{8'hA5, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // neither flag, stray data
      '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // stray words leave it empty
      '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h63, 1'b1, 1'b1, 1'b0, NO_DIGEST},     // byte on the last word goes in first
      '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h5A, 1'b0, 1'b1, 1'b0, NO_DIGEST},     // end without a byte
      '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},     // one-byte messages, both extremes
      '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST}
   };

   // sha-1 state of the behavioral model
   logic [31:0] chain_h [DIGEST_WORDS];
   logic [7:0]  block_bytes [BLOCK_BYTES];
   int unsigned block_fill;
   logic [63:0] message_bits;

   digest_word_type digest_words_due [$];

   int unsigned error_count   = 0;
   int unsigned words_checked = 0;
   int unsigned message_items = 0;
   int unsigned idle_items    = 0;
   int unsigned messages_done = 0;
   bit          sender_steady = 1'b0;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void sha1_restart();
      int i;
      for (i = 0; i < DIGEST_WORDS; i++) chain_h[i] = SHA1_IV[159 - 32*i -: 32];
      block_fill   = 0;
      message_bits = '0;
   endfunction

   // 80-round compression of the buffered block into the chaining words
   function automatic void sha1_fold_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      int r;
      for (r = 0; r < 16; r++)
         sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                     block_bytes[4*r+2], block_bytes[4*r+3]};
      for (r = 16; r < 80; r++)
         sched[r] = rotl32(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_CHOOSE;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_PARITY;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJOR;
         end else begin
            f = b ^ c ^ d;
            k = K_LAST;
         end
         t = rotl32(a, 5) + f + e + k + sched[r];
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void sha1_absorb(input logic [7:0] v);
      block_bytes[block_fill] = v;
      block_fill++;
      if (block_fill == BLOCK_BYTES) begin
         sha1_fold_block();
         block_fill = 0;
      end
   endfunction

   // advance the model by one accepted word, queue the digest on a last word
   function automatic void sha1_predict(input stim_row_type it);
      logic [63:0]     len_bits;
      digest_word_type dw;
      int k;
      if (it.has) begin
         message_bits += 64'd8;
         sha1_absorb(it.data);
      end
      if (it.last) begin
         len_bits = message_bits;
         sha1_absorb(PAD_MARK);
         while (block_fill != LEN_POS) sha1_absorb(8'h00);
         for (k = 0; k < LEN_BYTES; k++) sha1_absorb(len_bits[63 - 8*k -: 8]);
         for (k = 0; k < DIGEST_WORDS; k++) begin
            dw.word  = it.typed ? it.digest[159 - 32*k -: 32] : chain_h[k];
            dw.index = 3'(k);
            dw.last  = (k == DIGEST_WORDS - 1);
            digest_words_due.push_back(dw);
         end
         sha1_restart();
         messages_done++;
      end
   endfunction

   // no gap when steady; otherwise mostly back to back, sometimes a gap, rarely a long one
   function automatic int unsigned pick_gap(input bit steady);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // small messages most of the time, padding boundaries often, a few longer ones
   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(0, 12);
      if (r < 90) begin
         case ($urandom_range(0, 9))
            0:       return 55;
            1:       return 56;
            2:       return 57;
            3:       return 63;
            4:       return 64;
            5:       return 65;
            6:       return 119;
            7:       return 120;
            8:       return 127;
            default: return 128;
         endcase
      end
      return $urandom_range(13, 130);
   endfunction

   // offer one word, wait for the handshake, then maybe idle
   task automatic send_item(input stim_row_type it);
      int unsigned gap;
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= it.data;
      req_ch.has_byte  <= it.has;
      req_ch.last_byte <= it.last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sha1_predict(it);
      if (it.has || it.last) message_items++;
      else idle_items++;
      gap = pick_gap(sender_steady);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_message(input int unsigned len);
      stim_row_type it;
      bit           on_byte;
      int unsigned  i;
      it            = '0;
      sender_steady = ($urandom_range(0, 4) == 0);
      on_byte       = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         // stray word with neither flag now and then
         if ($urandom_range(0, 11) == 0) begin
            it.data = 8'($urandom);
            it.has  = 1'b0;
            it.last = 1'b0;
            send_item(it);
         end
         it.data = 8'($urandom);
         it.has  = 1'b1;
         it.last = on_byte && (i == len - 1);
         send_item(it);
      end
      if (!on_byte) begin
         it.data = 8'($urandom);
         it.has  = 1'b0;
         it.last = 1'b1;
         send_item(it);
      end
   endtask

   // stop offering until every queued digest word has come back
   task automatic drain_digests();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (digest_words_due.size() != 0) @(posedge clock);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // digest word checker and receiver stalls
   initial begin
      digest_word_type due;
      int unsigned     stall_left;
      int unsigned     steady_left;
      bit              hold_done;
      stall_left  = 0;
      steady_left = 0;
      hold_done   = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (digest_words_due.size() == 0) begin
               $error("digest word %h index %0d arrived with nothing expected",
                      rsp_ch.digest_word, rsp_ch.word_index);
               error_count++;
            end else begin
               due = digest_words_due.pop_front();
               if (rsp_ch.digest_word !== due.word) begin
                  $error("digest_word: expected %h, got %h", due.word, rsp_ch.digest_word);
                  error_count++;
               end
               if (rsp_ch.word_index !== due.index) begin
                  $error("word_index: expected %0d, got %0d", due.index, rsp_ch.word_index);
                  error_count++;
               end
               if (rsp_ch.last_word !== due.last) begin
                  $error("last_word: expected %0b, got %0b", due.last, rsp_ch.last_word);
                  error_count++;
               end
            end
            words_checked++;
         end
         // ready for the next edge
         if (!hold_done && words_checked >= HOLD_AFTER) begin
            // one long hold mid-digest so the engine backs up into req_ch
            hold_done  = 1'b1;
            stall_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (steady_left > 0) steady_left--;
            else if ($urandom_range(0, 39) == 0) steady_left = $urandom_range(30, 120);
            else stall_left = pick_gap(1'b0);
         end
      end
   end

   // stimulus
   initial begin
      int unsigned row;
      int unsigned random_msgs;
      random_msgs = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.has_byte  <= 1'b0;
      req_ch.last_byte <= 1'b0;
      sha1_restart();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (row = 0; row < DIRECTED_ROWS; row++) send_item(directed_rows[row]);
      drain_digests();

      // random messages
      while (message_items + idle_items < ITEM_TARGET) begin
         send_message(pick_length());
         random_msgs++;
         if (random_msgs == PAUSE_AT_MSG) drain_digests();
      end

      drain_digests();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run: %0d messages, %0d message words, %0d ignored words, %0d digest words",
               messages_done, message_items, idle_items, words_checked);
      $display("run: empty and one-byte messages, lengths up to 130 bytes across padding edges");
      if (error_count == 0 && digest_words_due.size() == 0) begin
         $display("sha1_message_digest test passed");
      end else begin
         $display("sha1_message_digest test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("sha1_message_digest test failed");
      $finish;
   end

endmodule
